[rtl/dtn_pkg.sv]
`timescale 1ns / 1ps
// dtn_pkg: shared types, constants and state encoding for the detection
// threshold / NMS block. No dependencies.
package dtn_pkg;

    localparam int DTN_MAX_CAND = 64;

    // configuration register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_OBJ_THR     = 2'd0;
    localparam logic [1:0] REG_SCORE_THR   = 2'd1;
    localparam logic [1:0] REG_OVERLAP_THR = 2'd2;

    localparam logic [15:0] OBJ_THR_RST     = 16'd16384;
    localparam logic [15:0] SCORE_THR_RST   = 16'd16384;
    localparam logic [15:0] OVERLAP_THR_RST = 16'd14746;

    localparam logic [15:0] CONF_MAX = 16'd32768;

    // one stored candidate, 104 bits
    typedef struct packed {
        logic signed [17:0] x1;
        logic signed [17:0] y1;
        logic signed [17:0] x2;
        logic signed [17:0] y2;
        logic [15:0]        conf;
        logic [15:0]        tag;
    } dtn_cand_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RESOLVE,
        ST_SEL_START,
        ST_SEL_RD,
        ST_SEL_CMP,
        ST_MARK,
        ST_SUP_RD,
        ST_SUP_W1,
        ST_SUP_W2,
        ST_SUP_W3,
        ST_SUP_W4,
        ST_SUP_CHK,
        ST_EMIT,
        ST_EMIT_NONE,
        ST_WAIT
    } dtn_state_t;

    typedef struct packed {
        logic store;       // filter and store the captured item
        logic idx_clr;
        logic idx_inc;
        logic rd_en;
        logic sel_cmp;     // compare read entry against best so far
        logic best_clr;
        logic mark_best;
        logic mark_sup;    // mark scanned entry if overlap too high
        logic emit_kept;
        logic emit_none;
        logic clear_frame;
    } dtn_cmd_t;

    typedef struct packed {
        logic frame_end;
        logic count_zero;
        logic idx_last;
        logic idx_done;
        logic out_free;
        logic out_last;
    } dtn_sts_t;

endpackage

[rtl/dtn_datapath.sv]
`timescale 1ns / 1ps
// dtn_datapath: input filter, candidate memory, done marks, best-pick
// register, overlap pipeline and output register. Uses dtn_pkg.
module dtn_datapath
    import dtn_pkg::*;
#(
    parameter int MAX_CANDIDATES = DTN_MAX_CAND,
    localparam int IW = $clog2(MAX_CANDIDATES),
    localparam int CW = $clog2(MAX_CANDIDATES + 1)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_accept,
    input  logic [15:0]        center_x,
    input  logic [15:0]        center_y,
    input  logic [15:0]        box_width,
    input  logic [15:0]        box_height,
    input  logic [15:0]        objectness,
    input  logic [15:0]        class_confidence,
    input  logic [15:0]        tag,
    input  logic               frame_end,
    input  logic [15:0]        obj_thr,
    input  logic [15:0]        score_thr,
    input  logic [15:0]        overlap_thr,
    input  dtn_cmd_t           cmd,
    output dtn_sts_t           sts,
    input  logic               out_stall,
    output logic               out_valid,
    output logic signed [17:0] left_edge,
    output logic signed [17:0] top_edge,
    output logic signed [17:0] right_edge,
    output logic signed [17:0] bottom_edge,
    output logic [15:0]        confidence,
    output logic [15:0]        kept_tag,
    output logic               entry_valid,
    output logic               store_overflow,
    output logic               last_of_frame
);

    // captured input item
    logic [15:0] cx_reg, cy_reg, w_reg, h_reg, obj_reg, cls_reg, tag_reg;
    logic        fe_reg;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cx_reg  <= center_x;
            cy_reg  <= center_y;
            w_reg   <= box_width;
            h_reg   <= box_height;
            obj_reg <= objectness;
            cls_reg <= class_confidence;
            tag_reg <= tag;
            fe_reg  <= frame_end;
        end
    end

    // filter and corner conversion
    logic [31:0] prod;
    logic        pass;
    dtn_cand_t   new_cand;

    always_comb
    begin
        prod = obj_reg * cls_reg;
        pass = (obj_reg >= obj_thr) && (prod >= {1'b0, score_thr, 15'd0});
        new_cand.x1 = $signed({2'b00, cx_reg}) - $signed({3'b000, w_reg[15:1]});
        new_cand.y1 = $signed({2'b00, cy_reg}) - $signed({3'b000, h_reg[15:1]});
        new_cand.x2 = new_cand.x1 + $signed({2'b00, w_reg});
        new_cand.y2 = new_cand.y1 + $signed({2'b00, h_reg});
        new_cand.conf = (prod[31:15] > {1'b0, CONF_MAX}) ? CONF_MAX : prod[30:15];
        new_cand.tag  = tag_reg;
    end

    // candidate memory
    dtn_cand_t mem [MAX_CANDIDATES];
    dtn_cand_t rd_data;
    logic [CW-1:0] count_reg;
    logic [IW-1:0] idx_reg;
    logic          overflow_reg;
    logic          room;

    assign room = count_reg < CW'(MAX_CANDIDATES);

    always_ff @(posedge clk)
    begin
        if (cmd.store && pass && room)
            mem[count_reg[IW-1:0]] <= new_cand;
        if (cmd.rd_en)
            rd_data <= mem[idx_reg];
    end

    logic [MAX_CANDIDATES-1:0] done_reg;
    dtn_cand_t     best_reg;
    logic [IW-1:0] best_idx_reg;
    logic          best_found_reg;
    logic          do_suppress;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            overflow_reg   <= 1'b0;
            idx_reg        <= '0;
            done_reg       <= '0;
            best_found_reg <= 1'b0;
        end
        else
        begin
            if (cmd.store && pass)
            begin
                if (room)
                    count_reg <= count_reg + 1'b1;
                else
                    overflow_reg <= 1'b1;
            end
            if (cmd.idx_clr)
                idx_reg <= '0;
            else if (cmd.idx_inc)
                idx_reg <= idx_reg + 1'b1;
            if (cmd.best_clr)
                best_found_reg <= 1'b0;
            else if (cmd.sel_cmp && !done_reg[idx_reg] &&
                     (!best_found_reg || rd_data.conf > best_reg.conf))
                best_found_reg <= 1'b1;
            if (cmd.mark_best)
                done_reg[best_idx_reg] <= 1'b1;
            if (cmd.mark_sup && do_suppress)
                done_reg[idx_reg] <= 1'b1;
            if (cmd.clear_frame)
            begin
                count_reg    <= '0;
                overflow_reg <= 1'b0;
                done_reg     <= '0;
            end
        end
    end

    // best pick payload; strict compare keeps the earliest on ties
    always_ff @(posedge clk)
    begin
        if (cmd.sel_cmp && !done_reg[idx_reg] &&
            (!best_found_reg || rd_data.conf > best_reg.conf))
        begin
            best_reg     <= rd_data;
            best_idx_reg <= idx_reg;
        end
    end

    // overlap pipeline: s1 dims, s2 areas, s3 union, s4 threshold product
    logic signed [17:0] xl, xr, yt, yb, dx, dy;
    logic [15:0] iw_s1, ih_s1, ow_s1, oh_s1, bw_s1, bh_s1;
    logic [31:0] inter_s2, area_o_s2, area_b_s2;
    logic [31:0] inter_s3;
    logic [32:0] uni_s3;
    logic [31:0] inter_s4;
    logic [48:0] thr_uni_s4;

    always_comb
    begin
        xl = (rd_data.x1 > best_reg.x1) ? rd_data.x1 : best_reg.x1;
        yt = (rd_data.y1 > best_reg.y1) ? rd_data.y1 : best_reg.y1;
        xr = (rd_data.x2 < best_reg.x2) ? rd_data.x2 : best_reg.x2;
        yb = (rd_data.y2 < best_reg.y2) ? rd_data.y2 : best_reg.y2;
        dx = xr - xl;
        dy = yb - yt;
    end

    always_ff @(posedge clk)
    begin
        if (xr >= xl && yb >= yt)
        begin
            iw_s1 <= dx[15:0];
            ih_s1 <= dy[15:0];
        end
        else
        begin
            iw_s1 <= '0;
            ih_s1 <= '0;
        end
        ow_s1 <= 16'(rd_data.x2 - rd_data.x1);
        oh_s1 <= 16'(rd_data.y2 - rd_data.y1);
        bw_s1 <= 16'(best_reg.x2 - best_reg.x1);
        bh_s1 <= 16'(best_reg.y2 - best_reg.y1);

        inter_s2  <= iw_s1 * ih_s1;
        area_o_s2 <= ow_s1 * oh_s1;
        area_b_s2 <= bw_s1 * bh_s1;

        inter_s3 <= inter_s2;
        uni_s3   <= {1'b0, area_o_s2} + {1'b0, area_b_s2} - {1'b0, inter_s2};

        inter_s4   <= inter_s3;
        thr_uni_s4 <= overlap_thr * uni_s3;
    end

    assign do_suppress = {2'b00, inter_s4, 15'd0} > thr_uni_s4;

    // candidates still open after the current marks
    logic [MAX_CANDIDATES-1:0] live;
    logic                      any_left;

    always_comb
    begin
        for (int i = 0; i < MAX_CANDIDATES; i++)
            live[i] = CW'(i) < count_reg;
        any_left = |(live & ~done_reg);
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (cmd.emit_kept || cmd.emit_none)
            out_valid <= 1'b1;
        else if (!out_stall)
            out_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_kept)
        begin
            left_edge      <= best_reg.x1;
            top_edge       <= best_reg.y1;
            right_edge     <= best_reg.x2;
            bottom_edge    <= best_reg.y2;
            confidence     <= best_reg.conf;
            kept_tag       <= best_reg.tag;
            entry_valid    <= 1'b1;
            store_overflow <= overflow_reg;
            last_of_frame  <= !any_left;
        end
        else if (cmd.emit_none)
        begin
            left_edge      <= '0;
            top_edge       <= '0;
            right_edge     <= '0;
            bottom_edge    <= '0;
            confidence     <= '0;
            kept_tag       <= '0;
            entry_valid    <= 1'b0;
            store_overflow <= overflow_reg;
            last_of_frame  <= 1'b1;
        end
    end

    always_comb
    begin
        sts.frame_end  = fe_reg;
        sts.count_zero = (count_reg == '0);
        sts.idx_last   = (CW'(idx_reg) == CW'(count_reg - 1'b1));
        sts.idx_done   = done_reg[idx_reg];
        sts.out_free   = !out_valid;
        sts.out_last   = last_of_frame;
    end

endmodule

[rtl/dtn_ctrl.sv]
`timescale 1ns / 1ps
// dtn_ctrl: sequencer for load, best-pick scan, suppression scan and
// emission. Uses dtn_pkg.
module dtn_ctrl
    import dtn_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_accept,
    input  dtn_sts_t sts,
    output dtn_cmd_t cmd,
    output logic     idle
);

    dtn_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (in_accept) state_next = ST_LOAD;
            ST_LOAD:      state_next = sts.frame_end ? ST_RESOLVE : ST_IDLE;
            ST_RESOLVE:   state_next = sts.count_zero ? ST_EMIT_NONE : ST_SEL_START;
            ST_SEL_START: state_next = ST_SEL_RD;
            ST_SEL_RD:    state_next = ST_SEL_CMP;
            ST_SEL_CMP:   state_next = sts.idx_last ? ST_MARK : ST_SEL_RD;
            ST_MARK:      state_next = ST_SUP_RD;
            ST_SUP_RD:
            begin
                if (!sts.idx_done)
                    state_next = ST_SUP_W1;
                else if (sts.idx_last)
                    state_next = ST_EMIT;
            end
            ST_SUP_W1:    state_next = ST_SUP_W2;
            ST_SUP_W2:    state_next = ST_SUP_W3;
            ST_SUP_W3:    state_next = ST_SUP_W4;
            ST_SUP_W4:    state_next = ST_SUP_CHK;
            ST_SUP_CHK:   state_next = sts.idx_last ? ST_EMIT : ST_SUP_RD;
            ST_EMIT:      state_next = ST_WAIT;
            ST_EMIT_NONE: state_next = ST_WAIT;
            ST_WAIT:
            begin
                if (sts.out_free)
                    state_next = sts.out_last ? ST_IDLE : ST_SEL_START;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        idle = 1'b0;
        case (state_reg)
            ST_IDLE:      idle = 1'b1;
            ST_LOAD:      cmd.store = 1'b1;
            ST_SEL_START:
            begin
                cmd.idx_clr  = 1'b1;
                cmd.best_clr = 1'b1;
            end
            ST_SEL_RD:    cmd.rd_en = 1'b1;
            ST_SEL_CMP:
            begin
                cmd.sel_cmp = 1'b1;
                cmd.idx_inc = !sts.idx_last;
            end
            ST_MARK:
            begin
                cmd.mark_best = 1'b1;
                cmd.idx_clr   = 1'b1;
            end
            ST_SUP_RD:
            begin
                cmd.rd_en   = !sts.idx_done;
                cmd.idx_inc = sts.idx_done && !sts.idx_last;
            end
            ST_SUP_CHK:
            begin
                cmd.mark_sup = 1'b1;
                cmd.idx_inc  = !sts.idx_last;
            end
            ST_EMIT:      cmd.emit_kept = 1'b1;
            ST_EMIT_NONE: cmd.emit_none = 1'b1;
            ST_WAIT:      cmd.clear_frame = sts.out_free && sts.out_last;
            default:      cmd = '0;
        endcase
    end

endmodule

[rtl/detection_threshold_nms_core.sv]
`timescale 1ns / 1ps
// detection_threshold_nms_core: top level with APB register file, sequencer
// and datapath. Uses dtn_pkg, dtn_ctrl, dtn_datapath.
//
// Usage:
//  - Input channel (in_valid/in_stall) takes one raw detection per item.
//    in_stall is high whenever the block is not idle.
//  - A non-final item is captured, then filtered and stored, and yields
//    no result. Survivors beyond MAX_CANDIDATES are dropped and flagged.
//  - The item with frame_end starts resolution over the N stored boxes.
//    Each kept box costs a best-pick scan that reads all N entries plus a
//    suppression scan that reads each open box and waits for its overlap
//    result through the pipeline, skipping closed ones, then an emit and
//    a wait for the result to drain. The memory's single read port, one
//    entry per access, sets the pace of these scans.
//  - Output channel (out_valid/out_stall) is a result register; a stall
//    simply holds the result and the sequencer waits for it to drain.
//  - A frame with no survivors gives one result with entry_valid low.
//  - Reset: thresholds to defaults, store empty, marks clear. No clearing
//    pass: the store is read only below the fill count.
//  - Config writes via APB (regs at 0x0, 0x4, 0x8) only while idle.
module detection_threshold_nms_core
    import dtn_pkg::*;
#(
    parameter int MAX_CANDIDATES = DTN_MAX_CAND
)
(
    input  logic               clk,
    input  logic               rst_n,
    // APB config port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [15:0]        center_x,
    input  logic [15:0]        center_y,
    input  logic [15:0]        box_width,
    input  logic [15:0]        box_height,
    input  logic [15:0]        objectness,
    input  logic [15:0]        class_confidence,
    input  logic [15:0]        tag,
    input  logic               frame_end,
    // output channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [17:0] left_edge,
    output logic signed [17:0] top_edge,
    output logic signed [17:0] right_edge,
    output logic signed [17:0] bottom_edge,
    output logic [15:0]        confidence,
    output logic [15:0]        kept_tag,
    output logic               entry_valid,
    output logic               store_overflow,
    output logic               last_of_frame
);

    logic [15:0] obj_thr_reg, score_thr_reg, overlap_thr_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            obj_thr_reg     <= OBJ_THR_RST;
            score_thr_reg   <= SCORE_THR_RST;
            overlap_thr_reg <= OVERLAP_THR_RST;
        end
        else if (cfg_wr && paddr[1:0] == 2'b00)
        begin
            case (paddr[3:2])
                REG_OBJ_THR:     obj_thr_reg     <= pwdata[15:0];
                REG_SCORE_THR:   score_thr_reg   <= pwdata[15:0];
                REG_OVERLAP_THR: overlap_thr_reg <= pwdata[15:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_OBJ_THR:     prdata = {16'd0, obj_thr_reg};
            REG_SCORE_THR:   prdata = {16'd0, score_thr_reg};
            REG_OVERLAP_THR: prdata = {16'd0, overlap_thr_reg};
            default:         prdata = '0;
        endcase
    end

    dtn_cmd_t cmd;
    dtn_sts_t sts;
    logic     idle;
    logic     in_accept;

    assign in_stall  = !idle;
    assign in_accept = in_valid && idle;

    dtn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .sts       (sts),
        .cmd       (cmd),
        .idle      (idle)
    );

    dtn_datapath #(
        .MAX_CANDIDATES (MAX_CANDIDATES)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_accept        (in_accept),
        .center_x         (center_x),
        .center_y         (center_y),
        .box_width        (box_width),
        .box_height       (box_height),
        .objectness       (objectness),
        .class_confidence (class_confidence),
        .tag              (tag),
        .frame_end        (frame_end),
        .obj_thr          (obj_thr_reg),
        .score_thr        (score_thr_reg),
        .overlap_thr      (overlap_thr_reg),
        .cmd              (cmd),
        .sts              (sts),
        .out_stall        (out_stall),
        .out_valid        (out_valid),
        .left_edge        (left_edge),
        .top_edge         (top_edge),
        .right_edge       (right_edge),
        .bottom_edge      (bottom_edge),
        .confidence       (confidence),
        .kept_tag         (kept_tag),
        .entry_valid      (entry_valid),
        .store_overflow   (store_overflow),
        .last_of_frame    (last_of_frame)
    );

endmodule
